// ===== rtl/core/lir_pkg.sv =====
// Shared constants, register indexes and control/status types for the
// linear interpolation resampler. No dependencies.
package lir_pkg;

  // Default widths handed to the top level parameters
  localparam int SAMPLE_BITS_DEF      = 24;
  localparam int FRAME_COUNT_BITS_DEF = 24;

  // Fraction bits of the Q.24 read position
  localparam int FRAC_BITS = 24;
  // Rounding bias: one half in the Q.24 fraction, added to products before truncation
  localparam int FRAC_HALF = 1 << (FRAC_BITS - 1);

  // Results emitted per source frame at most
  localparam int MAX_RESULTS = 64;
  localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

  // Configuration port
  localparam int RATE_W      = 19;
  localparam int STEP_W      = 32;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_INDEX_W = 3;

  localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_RATE   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TARGET_RATE   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PHASE_STEP    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_INPUT_FRAMES  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_OUTPUT_FRAMES = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_STEREO_INPUT  = 3'd5;

  // Register reset values
  localparam logic [RATE_W-1:0] SOURCE_RATE_RST = 19'd44100;
  localparam logic [RATE_W-1:0] TARGET_RATE_RST = 19'd48000;
  localparam logic [STEP_W-1:0] PHASE_STEP_RST  = 32'h0100_0000;
  localparam logic              STEREO_RST      = 1'b1;

  // Output value select, chosen when a result is staged
  localparam logic [1:0] SEL_LERP = 2'd0;
  localparam logic [1:0] SEL_CUR  = 2'd1;
  localparam logic [1:0] SEL_PREV = 2'd2;

  // Controller to datapath
  typedef struct packed {
    logic load;         // latch the input frame, restart buffer if done
    logic stage;        // register products and pick the output source
    logic emit;         // write one result to the output register
    logic commit;       // current frame becomes previous, count it
    logic emit_bypass;  // pass the frame straight through
  } lir_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic bypass;    // rates zero or equal
    logic flushing;  // all source frames taken
    logic can_emit;  // next position falls in the current interval, or last frame
    logic more;      // result budget and output count not used up
    logic out_free;  // output register can take a result this cycle
  } lir_status_t;

endpackage

// ===== rtl/core/lir_regs.sv =====
// Configuration register file of the resampler: six registers written over
// an index/data channel, plus the derived bypass flag and frame counts.
// Depends on lir_pkg.
module lir_regs
  import lir_pkg::*;
#(
  parameter int FRAME_COUNT_BITS = FRAME_COUNT_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [CFG_INDEX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_data,
  output logic [STEP_W-1:0]           phase_step,
  output logic [FRAME_COUNT_BITS-1:0] n_in,
  output logic [FRAME_COUNT_BITS-1:0] n_out,
  output logic                        stereo_input,
  output logic                        bypass
);

  logic [RATE_W-1:0]           source_rate;
  logic [RATE_W-1:0]           target_rate;
  logic [FRAME_COUNT_BITS-1:0] input_frames;
  logic [FRAME_COUNT_BITS-1:0] output_frames;

  // Writes are always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_rate   <= SOURCE_RATE_RST;
      target_rate   <= TARGET_RATE_RST;
      phase_step    <= PHASE_STEP_RST;
      input_frames  <= FRAME_COUNT_BITS'(1);
      output_frames <= FRAME_COUNT_BITS'(1);
      stereo_input  <= STEREO_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SOURCE_RATE:   source_rate   <= cfg_data[RATE_W-1:0];
        REG_TARGET_RATE:   target_rate   <= cfg_data[RATE_W-1:0];
        REG_PHASE_STEP:    phase_step    <= cfg_data[STEP_W-1:0];
        REG_INPUT_FRAMES:  input_frames  <= cfg_data[FRAME_COUNT_BITS-1:0];
        REG_OUTPUT_FRAMES: output_frames <= cfg_data[FRAME_COUNT_BITS-1:0];
        REG_STEREO_INPUT:  stereo_input  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Zero counts act as one
  assign n_in  = (input_frames == '0) ? FRAME_COUNT_BITS'(1) : input_frames;
  assign n_out = (output_frames == '0) ? FRAME_COUNT_BITS'(1) : output_frames;

  assign bypass = (source_rate == '0) || (target_rate == '0) ||
                  (source_rate == target_rate);

endmodule

// ===== rtl/core/lir_dp.sv =====
// Datapath of the resampler: frame registers, position accumulator, counters,
// interpolation multipliers and the output register.
// Depends on lir_pkg.
module lir_dp
  import lir_pkg::*;
#(
  parameter int SAMPLE_BITS      = SAMPLE_BITS_DEF,
  parameter int FRAME_COUNT_BITS = FRAME_COUNT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  lir_cmd_t                      cmd,
  output lir_status_t                   status,
  input  logic signed [SAMPLE_BITS-1:0] in_left,
  input  logic signed [SAMPLE_BITS-1:0] in_right,
  input  logic [STEP_W-1:0]             phase_step,
  input  logic [FRAME_COUNT_BITS-1:0]   n_in,
  input  logic [FRAME_COUNT_BITS-1:0]   n_out,
  input  logic                          stereo_input,
  input  logic                          bypass,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [SAMPLE_BITS-1:0]        out_left,
  output logic [SAMPLE_BITS-1:0]        out_right,
  output logic                          out_last
);

  localparam int POS_W  = FRAME_COUNT_BITS + FRAC_BITS;
  localparam int DIFF_W = SAMPLE_BITS + 1;
  localparam int PROD_W = DIFF_W + FRAC_BITS + 1;
  localparam int RND_W  = PROD_W - FRAC_BITS;

  // Frames
  logic signed [SAMPLE_BITS-1:0] cur_l, cur_r, prev_l, prev_r;
  // Buffer progress
  logic [FRAME_COUNT_BITS-1:0] taken, given;
  logic [POS_W-1:0]            pos;
  logic [RES_CNT_W-1:0]        k;
  // Staged result
  logic signed [PROD_W-1:0]    prod_l, prod_r;
  logic [1:0]                  sel;

  // Position fields and saturating advance
  logic [FRAME_COUNT_BITS-1:0] ipos;
  logic [FRAC_BITS-1:0]        frac;
  logic [POS_W:0]              pos_sum;
  logic [POS_W-1:0]            pos_adv;
  logic                        restart, lerp_ok, last_frame;

  assign ipos    = pos[POS_W-1:FRAC_BITS];
  assign frac    = pos[FRAC_BITS-1:0];
  assign pos_sum = {1'b0, pos} + (POS_W+1)'(phase_step);
  assign pos_adv = pos_sum[POS_W] ? '1 : pos_sum[POS_W-1:0];

  assign restart    = (taken >= n_in) && (bypass || (given >= n_out));
  assign last_frame = (taken == n_in - FRAME_COUNT_BITS'(1));
  assign lerp_ok    = (taken != '0) && (ipos < taken);

  assign status.bypass   = bypass;
  assign status.flushing = (taken >= n_in);
  assign status.can_emit = lerp_ok || last_frame;
  assign status.more     = (k < RES_CNT_W'(MAX_RESULTS)) && (given < n_out);
  assign status.out_free = !out_valid || out_ready;

  // Difference times fraction, one multiplier per channel
  logic signed [DIFF_W-1:0]    diff_l, diff_r;
  logic signed [FRAC_BITS:0]   frac_s;
  logic signed [PROD_W-1:0]    prod_l_next, prod_r_next;

  assign diff_l      = {cur_l[SAMPLE_BITS-1], cur_l} - {prev_l[SAMPLE_BITS-1], prev_l};
  assign diff_r      = {cur_r[SAMPLE_BITS-1], cur_r} - {prev_r[SAMPLE_BITS-1], prev_r};
  assign frac_s      = {1'b0, frac};
  assign prod_l_next = PROD_W'(diff_l) * PROD_W'(frac_s);
  assign prod_r_next = PROD_W'(diff_r) * PROD_W'(frac_s);

  // Round to nearest, ties up, then add to the previous sample
  logic signed [PROD_W-1:0] biased_l, biased_r;
  logic [RND_W-1:0]         sum_l, sum_r;
  logic [SAMPLE_BITS-1:0]   val_l, val_r;

  assign biased_l = prod_l + PROD_W'(FRAC_HALF);
  assign biased_r = prod_r + PROD_W'(FRAC_HALF);
  assign sum_l    = RND_W'(prev_l) + biased_l[PROD_W-1:FRAC_BITS];
  assign sum_r    = RND_W'(prev_r) + biased_r[PROD_W-1:FRAC_BITS];

  always_comb begin
    unique case (sel)
      SEL_LERP: begin
        val_l = sum_l[SAMPLE_BITS-1:0];
        val_r = sum_r[SAMPLE_BITS-1:0];
      end
      SEL_CUR: begin
        val_l = cur_l;
        val_r = cur_r;
      end
      default: begin
        val_l = prev_l;
        val_r = prev_r;
      end
    endcase
  end

  // Control state: counters, position, previous frame, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_l    <= '0;
      prev_r    <= '0;
      taken     <= '0;
      given     <= '0;
      pos       <= '0;
      k         <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load) begin
        k <= '0;
        if (restart) begin
          taken <= '0;
          given <= '0;
          pos   <= '0;
        end
      end else if (cmd.emit_bypass || cmd.commit) begin
        prev_l <= cur_l;
        prev_r <= cur_r;
        taken  <= taken + FRAME_COUNT_BITS'(1);
      end else if (cmd.emit) begin
        given <= given + FRAME_COUNT_BITS'(1);
        k     <= k + RES_CNT_W'(1);
        pos   <= pos_adv;
      end

      if (cmd.emit || cmd.emit_bypass) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_l <= in_left;
      cur_r <= stereo_input ? in_right : in_left;
    end
    if (cmd.stage) begin
      prod_l <= prod_l_next;
      prod_r <= prod_r_next;
      if (taken >= n_in) begin
        sel <= SEL_PREV;
      end else if (lerp_ok) begin
        sel <= SEL_LERP;
      end else begin
        sel <= SEL_CUR;
      end
    end
    if (cmd.emit_bypass) begin
      out_left  <= cur_l;
      out_right <= cur_r;
      out_last  <= last_frame;
    end else if (cmd.emit) begin
      out_left  <= val_l;
      out_right <= val_r;
      out_last  <= (given == n_out - FRAME_COUNT_BITS'(1));
    end
  end

endmodule

// ===== rtl/core/lir_ctrl.sv =====
// Controller of the resampler: takes one source frame, then passes it
// straight out in bypass or steps the datapath through stage/emit pairs
// until the frame's results are done. Depends on lir_pkg.
module lir_ctrl
  import lir_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  lir_status_t status,
  output lir_cmd_t    cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_DECIDE = 2'd1;
  localparam logic [1:0] S_EMIT   = 2'd2;

  logic [1:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (status.bypass) begin
          // one result, straight through
          if (status.out_free) begin
            cmd.emit_bypass = 1'b1;
            state_next      = S_IDLE;
          end
        end else if (status.more && (status.flushing || status.can_emit)) begin
          cmd.stage  = 1'b1;
          state_next = S_EMIT;
        end else begin
          // frame done; a flush call leaves the previous frame as it is
          cmd.commit = !status.flushing;
          state_next = S_IDLE;
        end
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_DECIDE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/linear_interp_resampler.sv =====
// Linear interpolation stereo resampler, one source frame per transaction.
// Each result is staged (difference times fraction registered) and then written
// to the output register; in bypass the frame goes straight to the output register.
// A frame yields at most 64 results; the next frame is taken only once they are all
// written, and output stalls hold the decide/stage/emit sequence.
// Reset: synchronous; registers return to defaults, counters and position clear.
module linear_interp_resampler
  import lir_pkg::*;
#(
  parameter int SAMPLE_BITS      = SAMPLE_BITS_DEF,
  parameter int FRAME_COUNT_BITS = FRAME_COUNT_BITS_DEF,
  localparam int DATA_W          = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                   clk,
  input  logic                   rst,
  // Source frames
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [DATA_W-1:0]      s_axis_tdata,   // left_in, right_in, zero pad
  // Output frames
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [DATA_W-1:0]      m_axis_tdata,   // left_out, right_out, zero pad
  output logic                   m_axis_tlast,
  // Register writes
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  lir_cmd_t                      cmd;
  lir_status_t                   status;
  logic [STEP_W-1:0]             phase_step;
  logic [FRAME_COUNT_BITS-1:0]   n_in, n_out;
  logic                          stereo_input, bypass;
  logic [SAMPLE_BITS-1:0]        out_left, out_right;

  lir_regs #(
    .FRAME_COUNT_BITS(FRAME_COUNT_BITS)
  ) u_regs (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .phase_step   (phase_step),
    .n_in         (n_in),
    .n_out        (n_out),
    .stereo_input (stereo_input),
    .bypass       (bypass)
  );

  lir_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  lir_dp #(
    .SAMPLE_BITS      (SAMPLE_BITS),
    .FRAME_COUNT_BITS (FRAME_COUNT_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .in_left      (s_axis_tdata[SAMPLE_BITS-1:0]),
    .in_right     (s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
    .phase_step   (phase_step),
    .n_in         (n_in),
    .n_out        (n_out),
    .stereo_input (stereo_input),
    .bypass       (bypass),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .out_left     (out_left),
    .out_right    (out_right),
    .out_last     (m_axis_tlast)
  );

  assign m_axis_tdata = DATA_W'({out_right, out_left});

  // No staging or output write while a new frame can be taken
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !(cmd.stage || cmd.emit || cmd.emit_bypass))
    else $error("datapath command issued while idle");

  // A taken frame keeps the input closed in the following cycle
  a_one_frame: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second frame taken back to back");

  // Every result write shows up on the output
  a_emit_shown: assert property (@(posedge clk) disable iff (rst)
    cmd.emit || cmd.emit_bypass |=> m_axis_tvalid)
    else $error("result written but not offered");

endmodule
